### sv/epsu_pkg.sv
// ----------------------------------------------------------------------------
// epsu_pkg
// Shared types and constants of the exact pattern search unit: item codes,
// register map, field widths and the pattern write word.
// ----------------------------------------------------------------------------
package epsu_pkg;

  // field widths fixed by the item format
  localparam int FUNC_W  = 2;
  localparam int PIDX_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int START_W = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  // item codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PATTERN = 2'd0,
    FUNC_TEXT    = 2'd1,
    FUNC_BEGIN   = 2'd2
  } func_e;

  // pattern store write word
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

endpackage

### sv/epsu_if.sv
// ----------------------------------------------------------------------------
// epsu_if
// Valid/ready channels of the exact pattern search unit: the item channel
// and the result channel.
// ----------------------------------------------------------------------------
interface epsu_in_if;
  import epsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIDX_W-1:0] pattern_index;
  logic [BYTE_W-1:0] data_byte;
  logic              text_last;

  modport source (
    output valid, func, pattern_index, data_byte, text_last,
    input  ready
  );
  modport sink (
    input  valid, func, pattern_index, data_byte, text_last,
    output ready
  );
endinterface

interface epsu_out_if;
  import epsu_pkg::*;

  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;
  logic               text_done;
  logic               none_found;
  logic               position_overflow;

  modport source (
    output valid, match_found, match_start, text_done, none_found, position_overflow,
    input  ready
  );
  modport sink (
    input  valid, match_found, match_start, text_done, none_found, position_overflow,
    output ready
  );
endinterface

### sv/epsu_cell.sv
// ----------------------------------------------------------------------------
// epsu_cell
// One window cell: holds one text byte, passes it on to the next cell on
// every text word and compares the incoming byte with its pattern byte.
// ----------------------------------------------------------------------------
module epsu_cell (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  logic [epsu_pkg::BYTE_W-1:0] byte_i,
  input  logic [epsu_pkg::BYTE_W-1:0] pat_i,
  output logic [epsu_pkg::BYTE_W-1:0] byte_o,
  output logic                        hit_o
);
  import epsu_pkg::*;

  logic [BYTE_W-1:0] byte_q;

  // window byte, moves one cell on per text word
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare against the window as it stands after this word
  assign hit_o  = (byte_i == pat_i);
  assign byte_o = byte_q;

endmodule

### sv/epsu_align.sv
// ----------------------------------------------------------------------------
// epsu_align
// Pattern store and aligner: keeps the pattern bytes by index and lines them
// up with the window so that window cell k sees pattern byte len-1-k.
// ----------------------------------------------------------------------------
module epsu_align #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                           clk_i,
  input  epsu_pkg::pat_wr_t              wr_i,
  input  logic [epsu_pkg::LEN_W-1:0]     len_i,
  output logic [MAX_PATTERN*epsu_pkg::BYTE_W-1:0] pat_o
);
  import epsu_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int SH_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int VEC_W  = MAX_PATTERN * BYTE_W;

  logic [BYTE_W-1:0] pat_q [MAX_PATTERN];
  logic [VEC_W-1:0]  rev_vec;
  logic [CMP_W-1:0]  sh_full;
  logic [SH_W-1:0]   sh;
  logic              len_ok;

  // pattern row, one write enable per entry
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (wr_i.en && (CMP_W'(wr_i.idx) == CMP_W'(k))) begin
        pat_q[k] <= wr_i.data;
      end
    end
    // reversed order: byte j holds pattern entry MAX_PATTERN-1-j
    assign rev_vec[k*BYTE_W +: BYTE_W] = pat_q[MAX_PATTERN-1-k];
  end

  // shift by MAX_PATTERN-len so that byte k becomes pattern entry len-1-k
  always_comb begin
    len_ok  = (len_i != '0) && (CMP_W'(len_i) <= CMP_W'(MAX_PATTERN));
    sh_full = len_ok ? (CMP_W'(MAX_PATTERN) - CMP_W'(len_i)) : '0;
    sh      = sh_full[SH_W-1:0];
    pat_o   = rev_vec >> {sh, 3'b000};
  end

endmodule

### sv/exact_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// exact_pattern_search_unit
// Streaming exact byte pattern search over a chain of window cells.
// ----------------------------------------------------------------------------
// Each text word gives one result word in the cycle after it is taken; pattern
// writes, begin words and unused codes give none. A new word is taken in
// every cycle in which the result register is empty or being read, so the
// unit runs at one word per cycle. All window cells compare in parallel in
// the cycle a text word is taken, against the pattern lined up by a barrel
// shifter on the pattern length, so every overlapping occurrence is found.
// Write pattern_length (register 0, address 0) only while no word is in
// flight; pattern bytes may be rewritten at any time through the word stream.
// ----------------------------------------------------------------------------
module exact_pattern_search_unit #(
  parameter int              MAX_PATTERN = 32,
  parameter longint unsigned MAX_TEXT    = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  epsu_in_if.sink                       in_i,
  epsu_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epsu_pkg::PADDR_W-1:0]  paddr,
  input  logic [epsu_pkg::PDATA_W-1:0]  pwdata,
  output logic [epsu_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import epsu_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int POS_W  = $clog2(MAX_TEXT);
  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_TEXT - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

  // configuration register
  logic [LEN_W-1:0]     len_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // text state
  logic [FILL_W-1:0] fill_q, fill_d, fill_new;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              any_q, any_d;
  logic              ovf_q, ovf_d;

  // result register
  logic               out_vld_q, out_vld_d;
  logic               match_q;
  logic [START_W-1:0] start_q;
  logic               done_q;
  logic               none_q;
  logic               ovfo_q;

  // word decode
  logic    in_rdy, in_acc;
  logic    is_text, is_begin;
  pat_wr_t pat_wr;

  // match path
  logic [MAX_PATTERN*BYTE_W-1:0] pat_vec;
  logic [BYTE_W-1:0]             chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0]        hit, in_use;
  logic                          len_ok, found, sat, ovf_new, any_new;
  logic [POS_W-1:0]              back, start;
  logic [POS_W+START_W-1:0]      start_ext;

  // apb register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_PATTERN_LENGTH);
  assign prdata  = (reg_idx == REG_PATTERN_LENGTH) ? PDATA_W'(len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_wr) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  // handshake and word decode
  assign in_rdy     = !out_vld_q || out_o.ready;
  assign in_i.ready = in_rdy;
  assign in_acc     = in_i.valid && in_rdy;

  always_comb begin
    is_text  = 1'b0;
    is_begin = 1'b0;
    unique case (in_i.func)
      FUNC_TEXT:  is_text  = 1'b1;
      FUNC_BEGIN: is_begin = 1'b1;
      default: ;
    endcase
  end

  assign pat_wr.en   = in_acc && (in_i.func == FUNC_PATTERN);
  assign pat_wr.idx  = in_i.pattern_index;
  assign pat_wr.data = in_i.data_byte;

  // pattern store, lined up with the window
  epsu_align #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_align (
    .clk_i (clk_i),
    .wr_i  (pat_wr),
    .len_i (len_q),
    .pat_o (pat_vec)
  );

  // window cells, newest byte enters cell 0
  assign chain[0] = in_i.data_byte;
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    epsu_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_acc && is_text),
      .byte_i  (chain[k]),
      .pat_i   (pat_vec[k*BYTE_W +: BYTE_W]),
      .byte_o  (chain[k+1]),
      .hit_o   (hit[k])
    );
    assign in_use[k] = (CMP_W'(k) < CMP_W'(len_q));
  end

  // match decision on the window after this byte
  always_comb begin
    fill_new  = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;
    len_ok    = (len_q != '0) && (CMP_W'(len_q) <= CMP_W'(MAX_PATTERN));
    found     = len_ok && (CMP_W'(fill_new) >= CMP_W'(len_q)) && (&(hit | ~in_use));
    sat       = (pos_q == POS_MAX);
    ovf_new   = ovf_q || sat;
    any_new   = any_q || found;
    back      = POS_W'(len_q - 1'b1);
    start     = (pos_q >= back) ? (pos_q - back) : '0;
    start_ext = {{START_W{1'b0}}, start};
  end

  // text state update
  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    any_d  = any_q;
    ovf_d  = ovf_q;
    if (in_acc && is_begin) begin
      fill_d = '0;
      pos_d  = '0;
      any_d  = 1'b0;
      ovf_d  = 1'b0;
    end else if (in_acc && is_text) begin
      fill_d = fill_new;
      pos_d  = sat ? pos_q : pos_q + 1'b1;
      any_d  = any_new;
      ovf_d  = ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      any_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      any_q  <= any_d;
      ovf_q  <= ovf_d;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (in_acc) begin
      out_vld_d = is_text;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_text) begin
      match_q <= found;
      start_q <= found ? start_ext[START_W-1:0] : '0;
      done_q  <= in_i.text_last;
      none_q  <= in_i.text_last && !any_new;
      ovfo_q  <= ovf_new;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.match_found       = match_q;
  assign out_o.match_start       = start_q;
  assign out_o.text_done         = done_q;
  assign out_o.none_found        = none_q;
  assign out_o.position_overflow = ovfo_q;

  // checks
  a_match_not_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(match_q && none_q))
    else $error("match and none_found reported together");

  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_begin) |=> (pos_q == '0 && fill_q == '0 && !any_q && !ovf_q))
    else $error("begin word did not clear the text state");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(in_acc && is_begin)) |=> ovf_q)
    else $error("overflow flag dropped within a text");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill beyond cell count");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exact pattern search unit. A typed stimulus
// table covers the corner cases first, then random pattern writes and texts
// run under several pattern lengths and handshake idling mixes. Every result
// word is checked field by field against a typed row or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;
  import epsu_pkg::*;

  localparam int PAT_DEPTH    = 32;
  localparam int unsigned POS_MAX = 65535;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 20000;
  localparam int PHASE_WORDS  = 75;

  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] LEN_ADDR    = PADDR_W'(4 * REG_PATTERN_LENGTH);

  // idling mix per random phase: none, sender, receiver, both
  localparam int SEND_IDLE  [4] = '{0, 45, 0, 13};
  localparam int RECV_STALL [4] = '{0, 0, 45, 13};
  localparam int PHASE_LEN  [4] = '{32, 1, 5, 0};

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic               text_done;
    logic               none_found;
    logic               position_overflow;
  } search_result_t;

  typedef enum logic {ROW_WORD, ROW_LEN} row_kind_e;

  // one directed step: a word to send, or a pattern length to program
  typedef struct packed {
    row_kind_e          kind;
    logic [FUNC_W-1:0]  func;
    logic [PIDX_W-1:0]  idx;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               typed;
    search_result_t     res;
  } dir_row_t;

  localparam search_result_t NO_RES = '0;
  localparam int N_ROWS = 30;

  localparam dir_row_t DIRECTED [N_ROWS] = '{
    // single byte pattern, match at index 0 then a miss on the last byte
    '{ROW_WORD, FUNC_PATTERN, 5'd0,  8'hA5, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b1, '{1'b1, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'h00, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b0, 1'b0}},
    // unused code, top pattern index
    '{ROW_WORD, FUNC_UNUSED,  5'd31, 8'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_PATTERN, 5'd31, 8'hFF, 1'b0, 1'b0, NO_RES},
    // new text with no match, then a byte beyond the last one
    '{ROW_WORD, FUNC_BEGIN,   5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd31, 8'hFF, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b0, 1'b0, 1'b0}},
    // three byte pattern, text shorter than the pattern, then a full match
    '{ROW_WORD, FUNC_PATTERN, 5'd1,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_PATTERN, 5'd2,  8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_LEN,  FUNC_PATTERN, 5'd0,  8'd3,  1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_BEGIN,   5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'h00, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, FUNC_BEGIN,   5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hFF, 1'b1, 1'b1, '{1'b1, 16'd0, 1'b1, 1'b0, 1'b0}},
    // overlapping matches of a repeated byte
    '{ROW_WORD, FUNC_PATTERN, 5'd1,  8'hA5, 1'b0, 1'b0, NO_RES},
    '{ROW_LEN,  FUNC_PATTERN, 5'd0,  8'd2,  1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_BEGIN,   5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b0, 1'b1, '{1'b1, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b1, 1'b0, 1'b0}},
    // lengths out of range never match
    '{ROW_LEN,  FUNC_PATTERN, 5'd0,  8'd0,  1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_BEGIN,   5'd0,  8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_LEN,  FUNC_PATTERN, 5'd0,  8'd63, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, FUNC_TEXT,    5'd0,  8'hA5, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_LEN,  FUNC_PATTERN, 5'd0,  8'd1,  1'b0, 1'b0, NO_RES}
  };

  logic clk_i;
  logic rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  epsu_in_if  in_ch ();
  epsu_out_if out_ch ();

  exact_pattern_search_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // search model state
  logic [BYTE_W-1:0] pat_mem   [PAT_DEPTH];
  logic [BYTE_W-1:0] win_bytes [PAT_DEPTH];
  int                win_fill;
  int unsigned       text_pos;
  bit                seen_match;
  bit                seen_overflow;
  logic [LEN_W-1:0]  pat_len;

  search_result_t pending_results [$];
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit long_stall_req;
  int stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_text();
    foreach (win_bytes[i]) win_bytes[i] = '0;
    win_fill      = 0;
    text_pos      = 0;
    seen_match    = 1'b0;
    seen_overflow = 1'b0;
  endfunction

  // advance the model by one accepted word; returns 1 when a result is due
  function automatic bit search_predict(input logic [FUNC_W-1:0] func,
                                        input logic [PIDX_W-1:0] pidx,
                                        input logic [BYTE_W-1:0] byte_in,
                                        input logic last,
                                        output search_result_t res);
    int unsigned idx;
    bit hit;
    res = '0;
    if (func == FUNC_PATTERN) begin
      pat_mem[pidx] = byte_in;
      return 1'b0;
    end
    if (func == FUNC_BEGIN) begin
      clear_text();
      return 1'b0;
    end
    if (func != FUNC_TEXT) return 1'b0;

    // shift the byte into the window, newest at entry 0
    for (int i = PAT_DEPTH - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = byte_in;
    if (win_fill < PAT_DEPTH) win_fill++;

    // position saturates at the top index
    idx = text_pos;
    if (idx >= POS_MAX) begin
      idx = POS_MAX;
      seen_overflow = 1'b1;
      text_pos = idx;
    end else begin
      text_pos = idx + 1;
    end

    hit = (pat_len >= 1) && (pat_len <= PAT_DEPTH) && (win_fill >= pat_len);
    for (int i = 0; i < PAT_DEPTH; i++) begin
      if (hit && i < pat_len && pat_mem[i] != win_bytes[pat_len - 1 - i]) hit = 1'b0;
    end
    if (hit) begin
      res.match_start = (idx >= pat_len - 1) ? START_W'(idx - (pat_len - 1)) : '0;
      seen_match = 1'b1;
    end
    res.match_found       = hit;
    res.text_done         = last;
    res.none_found        = last && !seen_match;
    res.position_overflow = seen_overflow;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [START_W-1:0] want,
                                      input logic [START_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    search_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no expectation waiting");
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("match_found", want.match_found, out_ch.match_found);
    check_field("match_start", want.match_start, out_ch.match_start);
    check_field("text_done", want.text_done, out_ch.text_done);
    check_field("none_found", want.none_found, out_ch.none_found);
    check_field("position_overflow", want.position_overflow, out_ch.position_overflow);
  endfunction

  // result side: check taken words, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
    if (long_stall_req) begin
      stall_left = LONG_STALL;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // offer one word, wait for it to be taken, then log what it should give
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [PIDX_W-1:0] pidx,
                           input logic [BYTE_W-1:0] data, input logic last,
                           input bit typed, input search_result_t typed_res);
    search_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= func;
    in_ch.pattern_index <= pidx;
    in_ch.data_byte     <= data;
    in_ch.text_last     <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (search_predict(func, pidx, data, last, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  // let every result drain and any silent word retire
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // program the pattern length, then read it back
  task automatic write_pattern_length(input logic [LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    pat_len = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== PDATA_W'(value)) begin
      $error("pattern_length readback: expected %0d, got %0d", value, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random texts built mostly from pattern copies, with noise words between
  task automatic run_texts(input int n_words);
    int sent;
    int tlen;
    int seg_left;
    int pos;
    int gen_len;
    int pick;
    bit copy;
    bit mangle;
    logic [BYTE_W-1:0] b;
    sent = 0;
    while (sent < n_words) begin
      gen_len = (pat_len >= 1 && pat_len <= PAT_DEPTH) ? int'(pat_len) : 4;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_word(FUNC_BEGIN, PIDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                  1'b0, NO_RES);
        tlen = $urandom_range(1, 2 * gen_len + 6);
        seg_left = 0;
        pos = 0;
        copy = 1'b0;
        mangle = 1'b0;
        for (int k = 0; k < tlen; k++) begin
          if (seg_left == 0) begin
            copy = ($urandom_range(0, 99) < 60);
            mangle = ($urandom_range(0, 4) == 0);
            seg_left = copy ? gen_len : $urandom_range(1, gen_len);
            pos = 0;
          end
          if (copy) begin
            b = pat_mem[pos];
            if (mangle && $urandom_range(0, gen_len - 1) == 0) b = ~b;
          end else if ($urandom_range(0, 3) == 0) begin
            b = BYTE_W'($urandom);
          end else begin
            b = pat_mem[$urandom_range(0, gen_len - 1)];
          end
          send_word(FUNC_TEXT, PIDX_W'($urandom), b, k == tlen - 1, 1'b0, NO_RES);
          pos++;
          seg_left--;
        end
        sent += tlen + 1;
      end else if (pick < 85) begin
        send_word(FUNC_PATTERN, PIDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                  1'b0, NO_RES);
        sent++;
      end else if (pick < 91) begin
        // ignored code, not counted
        send_word(FUNC_UNUSED, PIDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                  1'b0, NO_RES);
      end else begin
        // stray byte continuing whatever text is open
        send_word(FUNC_TEXT, PIDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                  1'b0, NO_RES);
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_stall_req = 1'b0;
    stall_left     = 0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    clear_text();
    pat_len = LEN_RESET;

    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_PATTERN;
    in_ch.pattern_index = '0;
    in_ch.data_byte     = '0;
    in_ch.text_last     = 1'b0;
    out_ch.ready        = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_LEN) begin
        wait_drained();
        write_pattern_length(DIRECTED[r].data[LEN_W-1:0]);
      end else begin
        send_word(DIRECTED[r].func, DIRECTED[r].idx, DIRECTED[r].data, DIRECTED[r].last,
                  DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    // fill the whole pattern store before any random text
    for (int i = 0; i < PAT_DEPTH; i++)
      send_word(FUNC_PATTERN, PIDX_W'(i), BYTE_W'($urandom), 1'($urandom), 1'b0, NO_RES);

    // random phases under different lengths and idling mixes
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_pattern_length(LEN_W'((p == 3) ? $urandom_range(2, 8) : PHASE_LEN[p]));
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      if (p == 0) long_stall_req = 1'b1;
      run_texts(PHASE_WORDS);
    end

    wait_drained();
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/epsu_pkg.sv
sv/epsu_if.sv
sv/epsu_cell.sv
sv/epsu_align.sv
sv/exact_pattern_search_unit.sv
test/tb_top.sv
